// ===== hdl/register_producer_scoreboard_unit_assert.svh =====
// Assertion macros shared by the scoreboard RTL.
`ifndef REGISTER_PRODUCER_SCOREBOARD_UNIT_ASSERT_SVH
`define REGISTER_PRODUCER_SCOREBOARD_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define RPSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define RPSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rpsb_pkg.sv =====
package rpsb_pkg;

  localparam int INT_REG_COUNT_DEF   = 32;
  localparam int FLOAT_REG_COUNT_DEF = 32;
  localparam int REGS_PER_ITEM_DEF   = 3;
  localparam int SEQ_BITS_DEF        = 16;

  // slots physically carried by one transaction
  localparam int SLOTS_CARRIED = 3;

  localparam int KIND_W  = 2;
  localparam int CLASS_W = 2;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 2;
  localparam int WAIT_W  = 16;
  localparam int SEQ_IN_W = 16;

  localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd3;

  localparam logic [CLASS_W-1:0] CLASS_INT   = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_FLOAT = 2'd1;

  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic flush;     // invalidate every entry
    logic rd;        // issue table read for the current slot
    logic eval;      // act on the read data for the current slot
    logic slot_inc;  // advance to the next slot
    logic out_load;  // move the result into the output register
  } cmd_t;

  typedef struct packed {
    logic whole_flush;  // flush, or faulting clear
    logic no_work;      // faulting item or no slots in use
    logic slot_last;    // current slot is the last one in use
  } sts_t;

endpackage

// ===== hdl/register_producer_scoreboard_unit.sv =====
// Register producer scoreboard: one tag per integer and float register holds
// the sequence number of its newest pending producer (0 means none). One
// transaction is handled at a time: after acceptance it passes a dispatch
// step, then a read and an evaluate step for each of the N register slots in
// use (0 to 3), then a finish step that loads the result; a flush, a faulting
// item or an item with no slots goes from dispatch straight to finish. The
// next transaction is taken only after the finish step. The tag RAM has a
// registered read port, so each slot needs its own read and evaluate steps.
// A result still waiting in the output register holds the controller in its
// finish step while out_tready stays low. Flushes and clears act on per-entry
// valid flags, so no clearing pass follows reset. Every transaction gives
// exactly one result; the output register lets the next transaction be taken
// while a result waits.
module register_producer_scoreboard_unit #(
  parameter int INT_REG_COUNT   = rpsb_pkg::INT_REG_COUNT_DEF,
  parameter int FLOAT_REG_COUNT = rpsb_pkg::FLOAT_REG_COUNT_DEF,
  parameter int REGS_PER_ITEM   = rpsb_pkg::REGS_PER_ITEM_DEF,
  parameter int SEQ_BITS        = rpsb_pkg::SEQ_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // seq_num[15:0], reg_count[17:16], reg0_class[19:18], reg0_index[24:20],
  // reg1_class[26:25], reg1_index[31:27], reg2_class[33:32],
  // reg2_index[38:34], zero[39]
  input  logic [39:0] in_tdata,
  // kind[1:0], fault[2]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // wait_seq[15:0]
  output logic [15:0] out_tdata
);

  import rpsb_pkg::*;

  `include "register_producer_scoreboard_unit_assert.svh"

  cmd_t cmd;
  sts_t sts;

  logic [CLASS_W-1:0] slot_class [SLOTS_CARRIED];
  logic [INDEX_W-1:0] slot_index [SLOTS_CARRIED];

  assign slot_class[0] = in_tdata[19:18];
  assign slot_index[0] = in_tdata[24:20];
  assign slot_class[1] = in_tdata[26:25];
  assign slot_index[1] = in_tdata[31:27];
  assign slot_class[2] = in_tdata[33:32];
  assign slot_index[2] = in_tdata[38:34];

  rpsb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rpsb_dpath #(
    .INT_REG_COUNT   (INT_REG_COUNT),
    .FLOAT_REG_COUNT (FLOAT_REG_COUNT),
    .REGS_PER_ITEM   (REGS_PER_ITEM),
    .SEQ_BITS        (SEQ_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_tuser[1:0]),
    .in_seq_num   (in_tdata[15:0]),
    .in_fault     (in_tuser[2]),
    .in_reg_count (in_tdata[17:16]),
    .in_class     (slot_class),
    .in_index     (slot_index),
    .out_wait_seq (out_tdata)
  );

  // one transaction in flight at a time
  `RPSB_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "took a second transaction while busy")
  // every evaluate step uses data read the cycle before
  `RPSB_ASSERT_NOW(a_eval_after_read, cmd.eval, $past(cmd.rd), "slot evaluated without a table read")
  // a result must never overwrite one still waiting
  `RPSB_ASSERT_NOW(a_no_result_overrun, cmd.out_load, !out_tvalid || out_tready, "pending result overwritten")

endmodule

// ===== hdl/rpsb_ram.sv =====
module rpsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/rpsb_ctrl.sv =====
module rpsb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  rpsb_pkg::sts_t sts,
  output rpsb_pkg::cmd_t cmd
);

  import rpsb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_EVAL,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.whole_flush) begin
          cmd.flush = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sts.no_work) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.slot_last) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.slot_inc = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_FINISH: begin
        // wait for the output register to drain
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== hdl/rpsb_dpath.sv =====
module rpsb_dpath #(
  parameter int INT_REG_COUNT   = rpsb_pkg::INT_REG_COUNT_DEF,
  parameter int FLOAT_REG_COUNT = rpsb_pkg::FLOAT_REG_COUNT_DEF,
  parameter int REGS_PER_ITEM   = rpsb_pkg::REGS_PER_ITEM_DEF,
  parameter int SEQ_BITS        = rpsb_pkg::SEQ_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpsb_pkg::cmd_t                 cmd,
  output rpsb_pkg::sts_t                 sts,
  input  logic [rpsb_pkg::KIND_W-1:0]    in_kind,
  input  logic [rpsb_pkg::SEQ_IN_W-1:0]  in_seq_num,
  input  logic                           in_fault,
  input  logic [rpsb_pkg::COUNT_W-1:0]   in_reg_count,
  input  logic [rpsb_pkg::CLASS_W-1:0]   in_class [rpsb_pkg::SLOTS_CARRIED],
  input  logic [rpsb_pkg::INDEX_W-1:0]   in_index [rpsb_pkg::SLOTS_CARRIED],
  output logic [rpsb_pkg::WAIT_W-1:0]    out_wait_seq
);

  import rpsb_pkg::*;

  localparam int TABLE_DEPTH = INT_REG_COUNT + FLOAT_REG_COUNT;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_CAP     = (REGS_PER_ITEM < SLOTS_CARRIED) ? REGS_PER_ITEM : SLOTS_CARRIED;
  localparam logic [COUNT_W-1:0] CNT_CAP_L = COUNT_W'(CNT_CAP);

  // captured transaction
  logic [KIND_W-1:0]   kind_r;
  logic                fault_r;
  logic [SEQ_BITS-1:0] seq_r;
  logic [COUNT_W-1:0]  cnt_r;
  logic [CLASS_W-1:0]  cls_r [SLOTS_CARRIED];
  logic [INDEX_W-1:0]  idx_r [SLOTS_CARRIED];

  logic [COUNT_W-1:0]     slot_r;
  logic [ADDR_W-1:0]      addr_r;
  logic                   hit_r;
  logic                   vld_q_r;
  logic [SEQ_BITS-1:0]    acc_r;
  logic [WAIT_W-1:0]      out_data_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  logic [COUNT_W-1:0]  cnt_in;
  logic [CLASS_W-1:0]  slot_cls;
  logic [INDEX_W-1:0]  slot_idx;
  logic [ADDR_W-1:0]   slot_addr;
  logic                slot_hit;
  logic [SEQ_BITS-1:0] rd_data;
  logic [SEQ_BITS-1:0] tag_cur;
  logic                mark_we;

  assign cnt_in = (in_reg_count > CNT_CAP_L) ? CNT_CAP_L : in_reg_count;

  assign slot_cls = cls_r[slot_r];
  assign slot_idx = idx_r[slot_r];

  // register number to table entry; out-of-class numbers are untracked
  always_comb begin
    slot_hit  = 1'b0;
    slot_addr = ADDR_W'(int'(slot_idx));
    if (slot_cls == CLASS_INT) begin
      slot_hit = int'(slot_idx) < INT_REG_COUNT;
    end else if (slot_cls == CLASS_FLOAT) begin
      slot_hit  = int'(slot_idx) < FLOAT_REG_COUNT;
      slot_addr = ADDR_W'(INT_REG_COUNT + int'(slot_idx));
    end
  end

  assign sts.whole_flush = (kind_r == KIND_FLUSH) || ((kind_r == KIND_CLEAR) && fault_r);
  assign sts.no_work     = fault_r || (cnt_r == '0);
  assign sts.slot_last   = (slot_r == (cnt_r - COUNT_W'(1)));

  // an invalid entry reads as no producer
  assign tag_cur = vld_q_r ? rd_data : '0;
  assign mark_we = cmd.eval && hit_r && (kind_r == KIND_MARK)
                   && ((seq_r > tag_cur) || (tag_cur == '0));

  rpsb_ram #(
    .WIDTH (SEQ_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (addr_r),
    .wdata (seq_r),
    .re    (cmd.rd),
    .raddr (slot_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      fault_r <= in_fault;
      seq_r   <= SEQ_BITS'(in_seq_num);
      cnt_r   <= cnt_in;
      for (int s = 0; s < SLOTS_CARRIED; s++) begin
        cls_r[s] <= in_class[s];
        idx_r[s] <= in_index[s];
      end
      slot_r <= '0;
      acc_r  <= '0;
    end
    if (cmd.slot_inc) begin
      slot_r <= slot_r + COUNT_W'(1);
    end
    if (cmd.rd) begin
      addr_r  <= slot_addr;
      hit_r   <= slot_hit;
      vld_q_r <= slot_hit && valid_r[slot_addr];
    end
    if (cmd.eval && hit_r && (kind_r == KIND_QUERY) && (tag_cur > acc_r)) begin
      acc_r <= tag_cur;
    end
    if (cmd.out_load) begin
      out_data_r <= WAIT_W'(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.flush) begin
      valid_r <= '0;
    end else if (mark_we) begin
      valid_r[addr_r] <= 1'b1;
    end else if (cmd.eval && hit_r && (kind_r == KIND_CLEAR)) begin
      valid_r[addr_r] <= 1'b0;
    end
  end

  assign out_wait_seq = out_data_r;

endmodule
